// ===== hw/rtl/lra_pkg.sv =====
`default_nettype none

package lra_pkg;

    // default ring depth
    localparam int MAX_LEDS_DEF = 32;

    // field widths
    localparam int FUNC_W      = 2;
    localparam int POS_W       = 8;
    localparam int LEN_W       = 8;
    localparam int COLOR_W     = 24;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int PIX_W       = 5;
    localparam int LED_COUNT_W = 6;
    localparam int WHIRL_W     = 8;
    localparam int PERIOD_W    = 16;
    localparam int MSPEED_W    = 4;
    localparam int PCT_W       = 7;
    localparam int PHASE_W     = 2;
    localparam int PROD_W      = 15;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHIRL_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHIRL_CW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH_PER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH_SPEED = 3'd5;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // morph phases
    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_RISE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_FALL = 2'd2;

    // animation constants
    localparam logic [PCT_W-1:0]       PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0]       MORPH_STEP = 7'd2;
    localparam logic [MSPEED_W-1:0]    STEP_BASE  = 4'd11;
    localparam logic [MSPEED_W-1:0]    MSPEED_MAX = 4'd10;
    localparam logic [WHIRL_W-1:0]     WHIRL_MAX  = 8'hFF;
    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 6'd32;

    // reciprocal of 100, exact for products below 2^15
    localparam int               RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
    localparam int               RECIP_SHIFT = 22;

    // divide a channel product by 100
    function automatic logic [CH_W-1:0] div100(input logic [PROD_W-1:0] x);
        logic [PROD_W+RECIP_W-1:0] prod;
        prod = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP_100);
        return prod[RECIP_SHIFT +: CH_W];
    endfunction

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic mod_step;
        logic wr;
        logic issue;
        logic advance;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              send;
        logic              len_zero;
        logic              mod_done;
        logic              wr_done;
        logic              issue_last;
        logic              pipe_go;
        logic              pipe_empty;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/lra_ctrl.sv =====
`default_nettype none

module lra_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire lra_pkg::t_stat i_stat,
    output lra_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_WRITE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ADVANCE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    assign o_s_tready = r_ready;

    // next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.func)
                    lra_pkg::FUNC_TICK: begin
                        n_state = i_stat.send ? ST_ISSUE : ST_ADVANCE;
                    end
                    lra_pkg::FUNC_SET: begin
                        n_state = i_stat.len_zero ? ST_IDLE : ST_MOD;
                    end
                    lra_pkg::FUNC_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.wr = 1'b1;
                if (i_stat.wr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ISSUE: begin
                if (i_stat.pipe_go) begin
                    o_cmd.issue = 1'b1;
                    if (i_stat.issue_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lra_datapath.sv =====
`default_nettype none

module lra_datapath #(
    parameter int MAX_LEDS = lra_pkg::MAX_LEDS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // latched item fields
    input  wire logic [lra_pkg::FUNC_W-1:0]    i_func,
    input  wire logic                          i_send,
    input  wire logic [lra_pkg::POS_W-1:0]     i_start_pos,
    input  wire logic [lra_pkg::LEN_W-1:0]     i_run_length,
    input  wire logic [lra_pkg::COLOR_W-1:0]   i_run_color,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [lra_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // control
    input  wire lra_pkg::t_cmd                 i_cmd,
    output lra_pkg::t_stat                     o_stat,
    // pixel stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [lra_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tlast
);

    localparam int IW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int NW   = $clog2(MAX_LEDS + 1);
    localparam int NW1  = NW + 1;
    localparam int MODW = 16;
    localparam int REMW = lra_pkg::POS_W + 1;
    localparam int MKW  = $clog2(lra_pkg::POS_W);

    // configuration registers
    logic [lra_pkg::LED_COUNT_W-1:0] r_led_count;
    logic [lra_pkg::COLOR_W-1:0]     r_bg_color;
    logic [lra_pkg::WHIRL_W-1:0]     r_whirl_speed;
    logic                            r_whirl_cw;
    logic [lra_pkg::PERIOD_W-1:0]    r_morph_period;
    logic [lra_pkg::MSPEED_W-1:0]    r_morph_speed;

    // animation state
    logic [IW-1:0]                   r_rot;
    logic [lra_pkg::WHIRL_W-1:0]     r_whirl_cnt;
    logic [lra_pkg::PHASE_W-1:0]     r_phase;
    logic [lra_pkg::PERIOD_W-1:0]    r_period_cnt;
    logic [lra_pkg::MSPEED_W-1:0]    r_step_cnt;
    logic [lra_pkg::PCT_W-1:0]       r_blend;

    // item registers
    logic [lra_pkg::FUNC_W-1:0]      r_func;
    logic                            r_send;
    logic [lra_pkg::POS_W-1:0]       r_rem;
    logic [MKW-1:0]                  r_mk;
    logic [lra_pkg::LEN_W-1:0]       r_len;
    logic [lra_pkg::COLOR_W-1:0]     r_color;
    logic [IW-1:0]                   r_ridx;

    // ring store
    logic [MAX_LEDS-1:0]             r_set;
    logic [lra_pkg::COLOR_W-1:0]     mem [MAX_LEDS];

    // pixel pipeline
    logic                            r_v1, r_v2, r_v3;
    logic [lra_pkg::COLOR_W-1:0]     r_s1_color;
    logic                            r_s1_set;
    logic [IW-1:0]                   r_s1_idx;
    logic                            r_s1_last;
    logic [lra_pkg::PROD_W-1:0]      r_s2_ca [lra_pkg::NUM_CH];
    logic [lra_pkg::PROD_W-1:0]      r_s2_cb [lra_pkg::NUM_CH];
    logic                            r_s2_set;
    logic [IW-1:0]                   r_s2_idx;
    logic                            r_s2_last;
    logic [lra_pkg::CH_W-1:0]        r_o_ch [lra_pkg::NUM_CH];
    logic [lra_pkg::PIX_W-1:0]       r_o_idx;
    logic [lra_pkg::PIX_W-1:0]       r_o_ofs;
    logic                            r_o_last;

    logic [NW-1:0]                   ring_n;
    logic [NW-1:0]                   n_last;
    logic                            go;
    logic                            issue_last;
    logic [MODW-1:0]                 mod_sub;
    logic [REMW-1:0]                 rem_inc;
    logic [NW1-1:0]                  rot_inc;
    logic [lra_pkg::MSPEED_W-1:0]    step_reload;
    logic [lra_pkg::PERIOD_W-1:0]    period_dec;
    logic [lra_pkg::MSPEED_W-1:0]    step_dec;
    logic [lra_pkg::PCT_W-1:0]       pct_inv;

    // ring size from led_count, clamped to one and to the depth
    always_comb begin
        if (r_led_count == '0) begin
            ring_n = NW'(1);
        end else if (32'(r_led_count) > 32'(MAX_LEDS)) begin
            ring_n = NW'(MAX_LEDS);
        end else begin
            ring_n = NW'(r_led_count);
        end
        n_last = ring_n - NW'(1);
    end

    assign go         = !r_v3 || i_m_tready;
    assign issue_last = (NW'(r_ridx) == n_last);
    assign mod_sub    = MODW'(ring_n) << r_mk;
    assign rem_inc    = REMW'(r_rem) + REMW'(1);
    assign rot_inc    = NW1'(r_rot) + NW1'(1);
    assign period_dec = r_period_cnt - lra_pkg::PERIOD_W'(1);
    assign step_dec   = r_step_cnt - lra_pkg::MSPEED_W'(1);
    assign pct_inv    = lra_pkg::PCT_FULL - r_blend;

    always_comb begin
        if (r_morph_speed > lra_pkg::MSPEED_MAX) begin
            step_reload = lra_pkg::STEP_BASE - lra_pkg::MSPEED_MAX;
        end else begin
            step_reload = lra_pkg::STEP_BASE - r_morph_speed;
        end
    end

    // status to controller
    always_comb begin
        o_stat.func       = r_func;
        o_stat.send       = r_send;
        o_stat.len_zero   = (r_len == '0);
        o_stat.mod_done   = (r_mk == '0);
        o_stat.wr_done    = (r_len == lra_pkg::LEN_W'(1));
        o_stat.issue_last = issue_last;
        o_stat.pipe_go    = go;
        o_stat.pipe_empty = !r_v1 && !r_v2;
    end

    // item fields, run position reduction and run walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_send  <= i_send;
            r_rem   <= i_start_pos;
            r_mk    <= MKW'(lra_pkg::POS_W - 1);
            r_len   <= i_run_length;
            r_color <= i_run_color;
        end else if (i_cmd.mod_step) begin
            // one conditional subtract of ring_n shifted, per cycle
            if (MODW'(r_rem) >= mod_sub) begin
                r_rem <= lra_pkg::POS_W'(MODW'(r_rem) - mod_sub);
            end
            r_mk <= r_mk - MKW'(1);
        end else if (i_cmd.wr) begin
            if (rem_inc >= REMW'(ring_n)) begin
                r_rem <= '0;
            end else begin
                r_rem <= lra_pkg::POS_W'(rem_inc);
            end
            r_len <= r_len - lra_pkg::LEN_W'(1);
        end
    end

    // pixel read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ridx <= '0;
        end else if (i_cmd.issue) begin
            r_ridx <= issue_last ? '0 : r_ridx + IW'(1);
        end
    end

    // set marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= '0;
        end else if (i_cmd.clear) begin
            r_set <= '0;
        end else if (i_cmd.wr) begin
            r_set[r_rem[IW-1:0]] <= 1'b1;
        end
    end

    // color store, one write and one registered read a cycle; a stalled master stream holds the read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_rem[IW-1:0]] <= r_color;
        end
        if (go) begin
            r_s1_color <= mem[r_ridx];
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (go) begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // pipeline payload: read, scale, divide and sum
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_set  <= r_set[r_ridx];
            r_s1_idx  <= r_ridx;
            r_s1_last <= issue_last;

            for (int ch = 0; ch < lra_pkg::NUM_CH; ch++) begin
                r_s2_ca[ch] <= lra_pkg::PROD_W'(r_s1_color[ch*lra_pkg::CH_W +: lra_pkg::CH_W])
                               * lra_pkg::PROD_W'(pct_inv);
                r_s2_cb[ch] <= lra_pkg::PROD_W'(r_bg_color[ch*lra_pkg::CH_W +: lra_pkg::CH_W])
                               * lra_pkg::PROD_W'(r_blend);
            end
            r_s2_set  <= r_s1_set;
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;

            for (int ch = 0; ch < lra_pkg::NUM_CH; ch++) begin
                if (r_s2_set) begin
                    r_o_ch[ch] <= lra_pkg::div100(r_s2_ca[ch]) + lra_pkg::div100(r_s2_cb[ch]);
                end else begin
                    r_o_ch[ch] <= r_bg_color[ch*lra_pkg::CH_W +: lra_pkg::CH_W];
                end
            end
            r_o_idx  <= lra_pkg::PIX_W'(r_s2_idx);
            r_o_ofs  <= lra_pkg::PIX_W'(r_rot);
            r_o_last <= r_s2_last;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {6'd0, r_o_ofs, r_o_ch[0], r_o_ch[1], r_o_ch[2], r_o_idx};

    // configuration, whirl and morph state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count    <= lra_pkg::LED_COUNT_RST;
            r_bg_color     <= '0;
            r_whirl_speed  <= '0;
            r_whirl_cw     <= 1'b1;
            r_morph_period <= '0;
            r_morph_speed  <= '0;
            r_rot          <= '0;
            r_whirl_cnt    <= lra_pkg::WHIRL_MAX;
            r_phase        <= lra_pkg::PHASE_IDLE;
            r_period_cnt   <= '0;
            r_step_cnt     <= '0;
            r_blend        <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_rot   <= '0;
                r_phase <= lra_pkg::PHASE_IDLE;
                r_blend <= '0;
            end

            if (i_cmd.advance) begin
                // whirl rotation
                if (r_whirl_speed != '0) begin
                    if (r_whirl_cnt == '0) begin
                        if (r_whirl_cw) begin
                            r_rot <= (rot_inc >= NW1'(ring_n)) ? '0 : IW'(rot_inc);
                        end else begin
                            r_rot <= (r_rot == '0) ? IW'(n_last) : r_rot - IW'(1);
                        end
                        r_whirl_cnt <= lra_pkg::WHIRL_MAX - r_whirl_speed;
                    end else begin
                        r_whirl_cnt <= r_whirl_cnt - lra_pkg::WHIRL_W'(1);
                    end
                end

                // morph machine
                case (r_phase)
                    lra_pkg::PHASE_IDLE: begin
                        if (r_morph_period != '0) begin
                            r_period_cnt <= period_dec;
                            if (period_dec == '0) begin
                                r_phase      <= lra_pkg::PHASE_RISE;
                                r_blend      <= '0;
                                r_step_cnt   <= step_reload;
                                r_period_cnt <= r_morph_period;
                            end
                        end
                    end
                    lra_pkg::PHASE_RISE: begin
                        r_step_cnt <= step_dec;
                        if (step_dec == '0) begin
                            if (r_blend < lra_pkg::PCT_FULL) begin
                                r_blend <= r_blend + lra_pkg::MORPH_STEP;
                            end else begin
                                r_phase <= lra_pkg::PHASE_FALL;
                            end
                            r_step_cnt <= step_reload;
                        end
                    end
                    lra_pkg::PHASE_FALL: begin
                        r_step_cnt <= step_dec;
                        if (step_dec == '0) begin
                            if (r_blend > '0) begin
                                r_blend <= r_blend - lra_pkg::MORPH_STEP;
                            end else begin
                                r_phase <= lra_pkg::PHASE_IDLE;
                            end
                            r_step_cnt <= step_reload;
                        end
                    end
                    default: begin
                        r_phase <= lra_pkg::PHASE_IDLE;
                    end
                endcase
            end

            // register writes, some reload the tick counters
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lra_pkg::REG_LED_COUNT: begin
                        r_led_count <= i_cfg_data[lra_pkg::LED_COUNT_W-1:0];
                    end
                    lra_pkg::REG_BG_COLOR: begin
                        r_bg_color <= i_cfg_data[lra_pkg::COLOR_W-1:0];
                    end
                    lra_pkg::REG_WHIRL_SPEED: begin
                        r_whirl_speed <= i_cfg_data[lra_pkg::WHIRL_W-1:0];
                        r_whirl_cnt   <= lra_pkg::WHIRL_MAX - i_cfg_data[lra_pkg::WHIRL_W-1:0];
                    end
                    lra_pkg::REG_WHIRL_CW: begin
                        r_whirl_cw  <= i_cfg_data[0];
                        r_whirl_cnt <= lra_pkg::WHIRL_MAX - r_whirl_speed;
                    end
                    lra_pkg::REG_MORPH_PER: begin
                        r_morph_period <= i_cfg_data[lra_pkg::PERIOD_W-1:0];
                        r_period_cnt   <= i_cfg_data[lra_pkg::PERIOD_W-1:0];
                    end
                    lra_pkg::REG_MORPH_SPEED: begin
                        r_morph_speed <= i_cfg_data[lra_pkg::MSPEED_W-1:0];
                        r_period_cnt  <= r_morph_period;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/led_ring_animator.sv =====
// LED ring animator. Items arrive on the slave stream: a set item colors a
// run of ring entries starting at start_pos modulo the ring size through an
// 8-step position reduction, then one store write per cycle. A tick with
// send reads one pixel per cycle from the color store, while the master
// stream does not stall, through a three-stage blend pipeline, then waits
// until the pipeline has emptied into its output register and steps the
// whirl and morph state; a tick without send only steps that state. A stalled
// master stream holds the pipeline. Registers must be written through
// i_cfg_we/i_cfg_idx/i_cfg_data only while no item is in progress; the block itself does not enforce it.
`default_nettype none

module led_ring_animator #(
    parameter int MAX_LEDS = lra_pkg::MAX_LEDS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // send [0], start_pos [8:1], run_length [16:9], run_color [40:17]
    input  wire logic [lra_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func [1:0]
    input  wire logic [lra_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // master stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // pixel_index [4:0], out_red [12:5], out_green [20:13], out_blue [28:21],
    // start_offset [33:29]
    output logic [lra_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tlast,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [lra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lra_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lra_pkg::t_cmd  cmd;
    lra_pkg::t_stat stat;

    // sequencer
    lra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // store, blend pipeline and animation state
    lra_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_func       (s_axis_tuser[lra_pkg::FUNC_W-1:0]),
        .i_send       (s_axis_tdata[0]),
        .i_start_pos  (s_axis_tdata[8:1]),
        .i_run_length (s_axis_tdata[16:9]),
        .i_run_color  (s_axis_tdata[40:17]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lra_checker.sv =====
`default_nettype none

module lra_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          i_s_tready,
    input wire logic                          i_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [lra_pkg::M_TDATA_W-1:0] i_m_tdata,
    input wire logic                          i_m_tlast
);

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("stalled pixel changed");

    // input ready is low in the cycle after each transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after a transaction");

    // pixels of a frame come in index order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && !i_m_tlast |=>
            !i_m_tvalid || (i_m_tdata[4:0] == $past(i_m_tdata[4:0]) + 5'd1))
        else $error("pixel index skipped within a frame");

    // the start offset stays fixed within a frame
    a_offset_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && !i_m_tlast |=>
            !i_m_tvalid || $stable(i_m_tdata[33:29]))
        else $error("start offset changed within a frame");

    // no pixel out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("pixel valid after reset");

endmodule

bind led_ring_animator lra_checker u_lra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/led_ring_animator_tb.sv =====
`timescale 1ns / 100ps

module led_ring_animator_tb;
    import lra_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RING_MAX      = 32;
    localparam int STALL_PCT     = 14;
    // wait that lets a set of 255 entries finish; a set gives no pixel
    localparam int SETTLE_CYCLES = 300;
    localparam int LIMIT_NS      = 2_000_000;

    // codes outside the documented lists
    localparam logic [FUNC_W-1:0]    FUNC_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [PIX_W-1:0] offset;
        logic             last;
    } t_pixel;

    // ring state mirror, computes the pixels each tick with send should emit
    class frame_predictor;
        logic [LED_COUNT_W-1:0] led_count;
        logic [COLOR_W-1:0]     bg_color;
        logic [WHIRL_W-1:0]     whirl_speed;
        logic                   whirl_cw;
        logic [PERIOD_W-1:0]    morph_period;
        logic [MSPEED_W-1:0]    morph_speed;

        logic                   entry_set [RING_MAX];
        logic [COLOR_W-1:0]     entry_color [RING_MAX];
        logic [PIX_W-1:0]       rotation;
        logic [WHIRL_W-1:0]     whirl_count;
        logic [PHASE_W-1:0]     morph_phase;
        logic [PERIOD_W-1:0]    period_count;
        logic [MSPEED_W-1:0]    step_count;
        logic [PCT_W-1:0]       blend_pct;

        t_pixel pending[$];
        int     errors;
        int     checked;
        int     items;
        int     rises;
        int     falls;

        function new();
            int i;
            led_count    = LED_COUNT_RST;
            bg_color     = '0;
            whirl_speed  = '0;
            whirl_cw     = 1'b1;
            morph_period = '0;
            morph_speed  = '0;
            for (i = 0; i < RING_MAX; i++) begin
                entry_set[i]   = 1'b0;
                entry_color[i] = '0;
            end
            rotation     = '0;
            whirl_count  = WHIRL_MAX;
            morph_phase  = PHASE_IDLE;
            period_count = '0;
            step_count   = '0;
            blend_pct    = '0;
            errors = 0;
            checked = 0;
            items = 0;
            rises = 0;
            falls = 0;
        endfunction

        function int ring_size();
            if (led_count == 0) return 1;
            if (led_count > RING_MAX) return RING_MAX;
            return int'(led_count);
        endfunction

        function logic [MSPEED_W-1:0] step_reload();
            return STEP_BASE - ((morph_speed > MSPEED_MAX) ? MSPEED_MAX : morph_speed);
        endfunction

        // one channel faded toward the background
        function logic [CH_W-1:0] mix(input logic [CH_W-1:0] c, input logic [CH_W-1:0] bg);
            int p;
            p = int'(blend_pct);
            return CH_W'((int'(c) * (int'(PCT_FULL) - p)) / int'(PCT_FULL)
                         + (int'(bg) * p) / int'(PCT_FULL));
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LED_COUNT:   led_count = data[LED_COUNT_W-1:0];
                REG_BG_COLOR:    bg_color = data[COLOR_W-1:0];
                REG_WHIRL_SPEED: begin
                    whirl_speed = data[WHIRL_W-1:0];
                    whirl_count = WHIRL_MAX - whirl_speed;
                end
                REG_WHIRL_CW: begin
                    whirl_cw    = data[0];
                    whirl_count = WHIRL_MAX - whirl_speed;
                end
                REG_MORPH_PER: begin
                    morph_period = data[PERIOD_W-1:0];
                    period_count = morph_period;
                end
                REG_MORPH_SPEED: begin
                    morph_speed  = data[MSPEED_W-1:0];
                    period_count = morph_period;
                end
                default: ;
            endcase
        endfunction

        // whirl rotation and morph machine, once per tick
        function void step_animation();
            int n;
            n = ring_size();
            if (whirl_speed != 0) begin
                if (whirl_count == 0) begin
                    if (whirl_cw)
                        rotation = (int'(rotation) + 1 >= n) ? '0 : rotation + 5'd1;
                    else
                        rotation = (rotation == 0) ? PIX_W'(n - 1) : rotation - 5'd1;
                    whirl_count = WHIRL_MAX - whirl_speed;
                end else begin
                    whirl_count = whirl_count - 8'd1;
                end
            end
            case (morph_phase)
                PHASE_IDLE: begin
                    if (morph_period != 0) begin
                        period_count = period_count - 16'd1;
                        if (period_count == 0) begin
                            morph_phase  = PHASE_RISE;
                            blend_pct    = '0;
                            step_count   = step_reload();
                            period_count = morph_period;
                            rises++;
                        end
                    end
                end
                PHASE_RISE: begin
                    step_count = step_count - 4'd1;
                    if (step_count == 0) begin
                        if (blend_pct < PCT_FULL) begin
                            blend_pct = blend_pct + MORPH_STEP;
                        end else begin
                            morph_phase = PHASE_FALL;
                            falls++;
                        end
                        step_count = step_reload();
                    end
                end
                PHASE_FALL: begin
                    step_count = step_count - 4'd1;
                    if (step_count == 0) begin
                        if (blend_pct > 0) blend_pct = blend_pct - MORPH_STEP;
                        else morph_phase = PHASE_IDLE;
                        step_count = step_reload();
                    end
                end
                default: morph_phase = PHASE_IDLE;
            endcase
        endfunction

        // accepted input transaction
        function void take_item(input logic [FUNC_W-1:0] func, input logic send,
                                input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len,
                                input logic [COLOR_W-1:0] color);
            int n;
            int i;
            int o;
            t_pixel px;
            n = ring_size();
            items++;
            case (func)
                FUNC_SET: begin
                    for (i = 0; i < int'(len); i++) begin
                        o = (int'(pos) + i) % n;
                        entry_set[o]   = 1'b1;
                        entry_color[o] = color;
                    end
                end
                FUNC_CLEAR: begin
                    for (i = 0; i < RING_MAX; i++) begin
                        entry_set[i]   = 1'b0;
                        entry_color[i] = '0;
                    end
                    rotation    = '0;
                    morph_phase = PHASE_IDLE;
                    blend_pct   = '0;
                end
                FUNC_TICK: begin
                    if (send) begin
                        for (i = 0; i < n; i++) begin
                            px.index = PIX_W'(i);
                            if (entry_set[i]) begin
                                px.red   = mix(entry_color[i][23:16], bg_color[23:16]);
                                px.green = mix(entry_color[i][15:8], bg_color[15:8]);
                                px.blue  = mix(entry_color[i][7:0], bg_color[7:0]);
                            end else begin
                                px.red   = bg_color[23:16];
                                px.green = bg_color[15:8];
                                px.blue  = bg_color[7:0];
                            end
                            px.offset = rotation;
                            px.last   = (i == n - 1);
                            pending.push_back(px);
                        end
                    end
                    step_animation();
                end
                default: ;
            endcase
        endfunction

        function void compare_field(input string field, input int want, input int got);
            if (want != got) begin
                $error("pixel %0s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // accepted output transaction against the oldest expected pixel
        function void check_pixel(input logic [M_TDATA_W-1:0] data, input logic tlast);
            t_pixel want;
            if (pending.size() == 0) begin
                $error("pixel transaction with nothing expected: tdata %h tlast %b",
                       data, tlast);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            compare_field("pixel_index", int'(want.index), int'(data[4:0]));
            compare_field("out_red", int'(want.red), int'(data[12:5]));
            compare_field("out_green", int'(want.green), int'(data[20:13]));
            compare_field("out_blue", int'(want.blue), int'(data[28:21]));
            compare_field("start_offset", int'(want.offset), int'(data[33:29]));
            compare_field("last", int'(want.last), int'(tlast));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    frame_predictor pred;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int reg_writes = 0;

    led_ring_animator #(
        .MAX_LEDS(RING_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= !(rx_stalls_on && $urandom_range(99) < STALL_PCT);
    end

    // pixel transactions
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pred.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    // one input transaction, called and returning at a falling edge
    task automatic push_item(input logic [FUNC_W-1:0] func, input logic send,
                             input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len,
                             input logic [COLOR_W-1:0] color);
        while (tx_gaps_on && $urandom_range(99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, color, len, pos, send};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        pred.take_item(func, send, pos, len, color);
        @(negedge i_clk);
    endtask

    // wait for every expected pixel, then let a set item finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pred.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        pred.write_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic setup_regs(input int leds, input int bg, input int wspeed, input int wcw,
                              input int mper, input int mspeed);
        write_reg(REG_LED_COUNT, CFG_DATA_W'(leds));
        write_reg(REG_BG_COLOR, CFG_DATA_W'(bg));
        write_reg(REG_WHIRL_SPEED, CFG_DATA_W'(wspeed));
        write_reg(REG_WHIRL_CW, CFG_DATA_W'(wcw));
        write_reg(REG_MORPH_PER, CFG_DATA_W'(mper));
        write_reg(REG_MORPH_SPEED, CFG_DATA_W'(mspeed));
    endtask

    // random items; spare-code items do not count toward the total
    task automatic random_items(input int count, input int tick_pct, input int send_pct);
        int done;
        int pick;
        logic [FUNC_W-1:0] func;
        logic send;
        logic [LEN_W-1:0] len;
        done = 0;
        while (done < count) begin
            send = 1'($urandom_range(1));
            len  = LEN_W'($urandom_range(255));
            if ($urandom_range(99) < tick_pct) begin
                func = FUNC_TICK;
                send = ($urandom_range(99) < send_pct);
            end else begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    func = FUNC_SET;
                    if ($urandom_range(9) != 0) len = LEN_W'($urandom_range(40));
                end else if (pick < 85) begin
                    func = FUNC_CLEAR;
                end else begin
                    func = FUNC_SPARE;
                end
            end
            push_item(func, send, POS_W'($urandom_range(255)), len, COLOR_W'($urandom()));
            if (func != FUNC_SPARE) done++;
        end
        drain();
    endtask

    initial begin
        pred = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, field extremes and every item kind
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        push_item(FUNC_SET, 1'b0, 8'd255, 8'd255, 24'hFFFFFF);
        push_item(FUNC_TICK, 1'b1, 8'd255, 8'd255, 24'hFFFFFF);
        push_item(FUNC_SET, 1'b1, 8'd0, 8'd0, 24'h123456);
        push_item(FUNC_SET, 1'b0, 8'd3, 8'd1, 24'h000000);
        push_item(FUNC_SPARE, 1'b1, 8'd255, 8'd255, 24'hFFFFFF);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        push_item(FUNC_CLEAR, 1'b1, 8'd255, 8'd255, 24'hFFFFFF);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        drain();

        // oversized ring, fastest counter-clockwise whirl, morph speed above max
        write_reg(REG_BG_COLOR, 24'hFF0000);
        write_reg(REG_WHIRL_SPEED, 24'd255);
        write_reg(REG_WHIRL_CW, 24'd0);
        write_reg(REG_MORPH_PER, 24'd1);
        write_reg(REG_MORPH_SPEED, 24'd15);
        write_reg(REG_LED_COUNT, 24'd63);
        push_item(FUNC_SET, 1'b0, 8'd5, 8'd4, 24'h00FF00);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        drain();

        // shrink the ring below the rotation, step both ways
        write_reg(REG_LED_COUNT, 24'd8);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        drain();
        write_reg(REG_WHIRL_CW, 24'd1);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        drain();

        // zero led count acts as a single LED; spare register indexes
        write_reg(REG_LED_COUNT, 24'd0);
        write_reg(REG_WHIRL_CW, 24'd0);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        push_item(FUNC_SET, 1'b0, 8'd200, 8'd3, 24'hA5C35A);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        drain();
        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'h000001);
        push_item(FUNC_TICK, 1'b1, 8'd0, 8'd0, 24'h000000);
        drain();

        // full ring, no animation
        setup_regs(32, $urandom(), 0, 1, 0, 0);
        random_items(20, 40, 50);

        // small ring, fast morph through rise and fall, no idling
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        setup_regs($urandom_range(1, 8), $urandom(), 250, $urandom_range(1), 2, 10);
        push_item(FUNC_CLEAR, 1'b0, 8'd0, 8'd0, 24'h000000);
        random_items(60, 95, 15);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;

        // everything random
        setup_regs($urandom_range(63), $urandom(), $urandom_range(255), $urandom_range(1),
                   $urandom_range(20), $urandom_range(15));
        random_items(20, 50, 40);

        // single LED, white background, longest morph period
        setup_regs(1, 24'hFFFFFF, 0, 0, 65535, 0);
        random_items(10, 50, 60);

        setup_regs($urandom_range(63), $urandom(), 255, $urandom_range(1), 1, 15);
        random_items(10, 60, 40);

        $display("covered %0d items, %0d pixels, %0d register writes",
                 pred.items, pred.checked, reg_writes);
        $display("morph rises %0d, falls %0d, errors %0d", pred.rises, pred.falls, pred.errors);
        if (pred.errors == 0)
            $display("led_ring_animator_tb passed");
        else
            $display("led_ring_animator_tb failed");
        $finish;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("led_ring_animator_tb failed");
        $finish;
    end

endmodule
